### sv/kss_pkg.sv
package kss_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CODE_W = 3;
	localparam int PERIOD_W = 8;
	localparam int LIMIT_W = 16;
	localparam int HOLD_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RESET = 8'd20;
	localparam logic [LIMIT_W-1:0] LONG_PRESS_RESET = 16'd1000;

	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_LIMIT = 2'd1;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;
	localparam logic [CODE_W-1:0] CODE_ONE = 3'd1;
	localparam logic [CODE_W-1:0] CODE_TWO = 3'd2;
	localparam logic [CODE_W-1:0] CODE_THREE = 3'd3;
	localparam logic [CODE_W-1:0] CODE_LONG = 3'd4;

	typedef struct packed {
		logic valid;
		logic [CODE_W-1:0] code;
	} event_push_t;

endpackage

### sv/kss_scan.sv
module kss_scan (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [kss_pkg::CFG_IDX_W-1:0] wr_index,
	input logic [kss_pkg::CFG_DATA_W-1:0] wr_data,
	input logic tick,
	input logic button_one_level,
	input logic button_two_level,
	input logic button_three_level,
	output kss_pkg::event_push_t push
);

	logic [kss_pkg::PERIOD_W-1:0] scan_period_q;
	logic [kss_pkg::LIMIT_W-1:0] long_press_limit_q;
	logic [kss_pkg::HOLD_W-1:0] hold_q;
	logic [kss_pkg::PERIOD_W-1:0] divider_q;
	logic [kss_pkg::CODE_W-1:0] current_code_q;

	logic [kss_pkg::HOLD_W-1:0] hold_next;
	logic [kss_pkg::PERIOD_W-1:0] divider_inc;
	logic sample;
	logic [kss_pkg::CODE_W-1:0] code_new;

	always_comb begin
		if (!button_three_level) begin
			hold_next = (hold_q == {kss_pkg::HOLD_W{1'b1}}) ? hold_q
				: hold_q + kss_pkg::HOLD_W'(1);
		end else begin
			hold_next = '0;
		end
	end

	assign divider_inc = divider_q + kss_pkg::PERIOD_W'(1);
	assign sample = (divider_inc >= scan_period_q);

	// The long-press compare uses the hold count as updated by this tick.
	always_comb begin
		if (!button_one_level) begin
			code_new = kss_pkg::CODE_ONE;
		end else if (!button_two_level) begin
			code_new = kss_pkg::CODE_TWO;
		end else if (!button_three_level && (hold_next > long_press_limit_q)) begin
			code_new = kss_pkg::CODE_LONG;
		end else if (!button_three_level) begin
			code_new = kss_pkg::CODE_THREE;
		end else begin
			code_new = kss_pkg::CODE_NONE;
		end
	end

	assign push.valid = tick && sample && (current_code_q != kss_pkg::CODE_NONE)
		&& (code_new == kss_pkg::CODE_NONE);
	assign push.code = current_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q <= kss_pkg::SCAN_PERIOD_RESET;
			long_press_limit_q <= kss_pkg::LONG_PRESS_RESET;
		end else if (wr_en) begin
			case (wr_index)
				kss_pkg::CFG_SCAN_PERIOD: begin
					scan_period_q <= wr_data[kss_pkg::PERIOD_W-1:0];
				end
				kss_pkg::CFG_LONG_PRESS_LIMIT: begin
					long_press_limit_q <= wr_data[kss_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			divider_q <= '0;
			current_code_q <= kss_pkg::CODE_NONE;
		end else if (tick) begin
			hold_q <= hold_next;
			if (sample) begin
				divider_q <= '0;
				current_code_q <= code_new;
			end else begin
				divider_q <= divider_inc;
			end
		end
	end

endmodule

### sv/kss_fifo.sv
module kss_fifo (
	input logic clk,
	input logic arst_n,
	input kss_pkg::event_push_t push,
	input logic pop,
	output logic [kss_pkg::CODE_W-1:0] pop_code
);

	logic [kss_pkg::CODE_W-1:0] store_q [kss_pkg::QUEUE_DEPTH];
	logic [kss_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [kss_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [kss_pkg::QCNT_W-1:0] count_q;

	logic empty;
	logic full;
	logic do_push;
	logic do_pop;

	assign empty = (count_q == '0);
	assign full = (count_q == kss_pkg::QCNT_W'(kss_pkg::QUEUE_DEPTH));
	assign do_push = push.valid && !full;
	assign do_pop = pop && !empty;

	assign pop_code = empty ? kss_pkg::CODE_NONE : store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == kss_pkg::QPTR_W'(kss_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + kss_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == kss_pkg::QPTR_W'(kss_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + kss_pkg::QPTR_W'(1);
			end
			// A tick and a read never arrive in the same transaction.
			if (do_push && !do_pop) begin
				count_q <= count_q + kss_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - kss_pkg::QCNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= kss_pkg::QCNT_W'(kss_pkg::QUEUE_DEPTH))
		else $error("event count exceeds queue depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> (rd_ptr_q == wr_ptr_q))
		else $error("pointers disagree with empty or full count");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(full && push.valid && !pop) |=> (full && $stable(wr_ptr_q)))
		else $error("push into full queue changed its state");

endmodule

### sv/kss_outbuf.sv
module kss_outbuf (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [kss_pkg::CODE_W-1:0] push_code,
	output logic full,
	output logic out_valid,
	input logic out_stall,
	output logic [kss_pkg::CODE_W-1:0] key_code
);

	logic out_valid_q;
	logic [kss_pkg::CODE_W-1:0] out_code_q;
	logic skid_valid_q;
	logic [kss_pkg::CODE_W-1:0] skid_code_q;
	logic take;

	assign out_valid = out_valid_q;
	assign key_code = out_code_q;
	assign full = skid_valid_q;
	assign take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take) begin
					out_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (!out_valid_q || take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_code_q <= skid_code_q;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_code_q <= push_code;
			end else begin
				skid_code_q <= push_code;
			end
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("result pushed into a full output buffer");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && take) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry not moved to output");

endmodule

### sv/key_scanner_long_press_event_fifo_unit.sv
// Channel   Handshake            Payload
// in        in_valid / in_stall  op, button_one_level, button_two_level, button_three_level
// out       out_valid / out_stall key_code
// config    wr_en                wr_index, wr_data
//
// One transaction is taken in every cycle while in_stall is low; its result is
// registered in the output register, or in the skid entry if the output stalls.
// Scan, hold and queue state all update at the input edge in one pass.
// A two-entry output buffer lets one more transaction in while out_stall holds;
// in_stall rises only when both entries are held.
// Reset clears all control state and restores the register reset values.
module key_scanner_long_press_event_fifo_unit (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [kss_pkg::CFG_IDX_W-1:0] wr_index,
	input logic [kss_pkg::CFG_DATA_W-1:0] wr_data,
	input logic in_valid,
	output logic in_stall,
	input logic op,
	input logic button_one_level,
	input logic button_two_level,
	input logic button_three_level,
	output logic out_valid,
	input logic out_stall,
	output logic [kss_pkg::CODE_W-1:0] key_code
);

	logic accept;
	logic tick;
	logic pop;
	logic buf_full;
	kss_pkg::event_push_t push;
	logic [kss_pkg::CODE_W-1:0] pop_code;
	logic [kss_pkg::CODE_W-1:0] result_code;

	assign in_stall = buf_full;
	assign accept = in_valid && !buf_full;
	assign tick = accept && (op == kss_pkg::OP_TICK);
	assign pop = accept && (op == kss_pkg::OP_READ);
	assign result_code = (op == kss_pkg::OP_READ) ? pop_code : kss_pkg::CODE_NONE;

	kss_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.tick(tick),
		.button_one_level(button_one_level),
		.button_two_level(button_two_level),
		.button_three_level(button_three_level),
		.push(push)
	);

	kss_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(pop),
		.pop_code(pop_code)
	);

	kss_outbuf u_outbuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_code(result_code),
		.full(buf_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_code(key_code)
	);

endmodule
